FILE: rtl/fftd_pkg.sv
// ----------------------------------------------------------------------------
// fftd_pkg
// Shared types and constants for the float frame tail detector.
// ----------------------------------------------------------------------------
package fftd_pkg;

    localparam int MAX_FRAME_BYTES = 8192;
    localparam int COUNT_CAP       = MAX_FRAME_BYTES + 4;
    localparam int COUNT_W         = $clog2(COUNT_CAP + 1);

    localparam logic [31:0] TAIL_WORD = 32'h7F80_0000;
    localparam logic [31:0] MAG_LIMIT = 32'h4E6E_6B28;
    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;

    localparam logic [7:0] HIT_MAX = 8'hFF;

    // operation codes
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] byte_value;
    } item_word_t;

    typedef struct packed {
        logic       frame_valid;
        logic       frame_rejected;
        logic       detected;
        logic [7:0] hit_total;
    } result_word_t;

    typedef struct packed {
        logic [23:0]        recent_bytes;
        logic [COUNT_W-1:0] frame_byte_count;
        logic               bad_word_seen;
        logic [7:0]         hit_count;
        logic               detect_latched;
    } fftd_state_t;

endpackage

FILE: rtl/fftd_step.sv
// ----------------------------------------------------------------------------
// fftd_step
// Per-byte next-state and result logic: tail match, word check, hit count.
// ----------------------------------------------------------------------------
module fftd_step
    import fftd_pkg::*;
(
    input  fftd_state_t  state_cur,
    input  logic [7:0]   threshold,
    input  item_word_t   item,
    output fftd_state_t  state_nxt,
    output result_word_t result
);

    logic [31:0]        word;
    logic               saturated;
    logic               tail_hit;
    logic [COUNT_W-1:0] data_len;
    logic               frame_ok;
    logic [7:0]         thr_eff;
    logic [7:0]         hit_inc;
    logic               fv;
    logic               fr;

    assign word      = {item.byte_value, state_cur.recent_bytes};
    assign saturated = (state_cur.frame_byte_count >= COUNT_W'(COUNT_CAP));
    assign tail_hit  = (state_cur.frame_byte_count >= COUNT_W'(3)) && (word == TAIL_WORD);
    assign data_len  = state_cur.frame_byte_count - COUNT_W'(3);
    assign frame_ok  = !saturated && (data_len != '0) && (data_len[1:0] == 2'b00)
                       && (data_len <= COUNT_W'(MAX_FRAME_BYTES))
                       && !state_cur.bad_word_seen;
    assign thr_eff   = (threshold == 8'd0) ? 8'd1 : threshold;
    assign hit_inc   = (state_cur.hit_count == HIT_MAX) ? state_cur.hit_count
                                                        : state_cur.hit_count + 8'd1;

    always_comb
    begin
        state_nxt = state_cur;
        fv        = 1'b0;
        fr        = 1'b0;
        if (item.operation == OP_RESTART)
        begin
            state_nxt = '0;
        end
        else if (!state_cur.detect_latched)
        begin
            if (tail_hit)
            begin
                if (frame_ok)
                begin
                    fv                  = 1'b1;
                    state_nxt.hit_count = hit_inc;
                    if (hit_inc >= thr_eff)
                    begin
                        state_nxt.detect_latched = 1'b1;
                    end
                end
                else
                begin
                    fr = 1'b1;
                end
                state_nxt.recent_bytes     = '0;
                state_nxt.frame_byte_count = '0;
                state_nxt.bad_word_seen    = 1'b0;
            end
            else
            begin
                if (!saturated)
                begin
                    // word completes when the new byte is the fourth of a group
                    if ((state_cur.frame_byte_count[1:0] == 2'b11)
                        && ((word & MAG_MASK) > MAG_LIMIT))
                    begin
                        state_nxt.bad_word_seen = 1'b1;
                    end
                    state_nxt.frame_byte_count = state_cur.frame_byte_count + COUNT_W'(1);
                end
                state_nxt.recent_bytes = {item.byte_value, state_cur.recent_bytes[23:8]};
            end
        end
    end

    assign result.frame_valid    = fv;
    assign result.frame_rejected = fr;
    assign result.detected       = state_nxt.detect_latched;
    assign result.hit_total      = state_nxt.hit_count;

endmodule

FILE: rtl/float_frame_tail_detector.sv
// ----------------------------------------------------------------------------
// float_frame_tail_detector
// Finds little-endian float frames ended by 00 00 80 7F and latches detection.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while item_ready is high, and each byte
// yields exactly one result word, registered into the output or skid slot.
// The per-byte update (tail compare, word magnitude check, frame length and
// hit counters) is a single pass of logic from the state registers into the
// state and result registers, so the rate is one byte per cycle unless
// stalled. The result side has a two-entry buffer (output register plus skid
// register), so item_ready drops only when both hold words that the consumer
// has not taken. A restart word clears the frame and hit state; the threshold
// register keeps its value and may be written only while no result is pending.
module float_frame_tail_detector
    import fftd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    // byte input channel
    input  logic         item_valid,
    output logic         item_ready,
    input  item_word_t   item,

    // result channel
    output logic         result_valid,
    input  logic         result_ready,
    output result_word_t result,

    // threshold register write
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);

    fftd_state_t  state_reg;
    fftd_state_t  state_next;
    result_word_t step_result;

    logic [7:0]   threshold_reg;

    logic         out_valid_reg;
    logic         out_valid_next;
    result_word_t out_reg;
    result_word_t out_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    result_word_t skid_reg;
    result_word_t skid_next;

    logic         accept;
    logic         pop;

    // input stalls only when both result slots are occupied
    assign item_ready   = !skid_valid_reg;
    assign accept       = item_valid && item_ready;
    assign pop          = out_valid_reg && result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // per-byte update logic
    fftd_step u_step (
        .state_cur (state_reg),
        .threshold (threshold_reg),
        .item      (item),
        .state_nxt (state_next),
        .result    (step_result)
    );

    // threshold register, reset value 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // detector state advances on every accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // output register and skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no accept possible here; drain skid into output on pop
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_next       = step_result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = step_result;
                out_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload slots carry no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // a tail is either a hit or a reject, never both
    a_fv_fr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.frame_valid && result.frame_rejected))
        else $error("frame_valid and frame_rejected both set");

    // latched detection needs at least one counted hit
    a_latch_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.detect_latched |-> (state_reg.hit_count != 8'd0))
        else $error("detection latched with zero hits");

    // an accepted restart clears frame and hit state
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation == OP_RESTART)) |=>
            ((state_reg.hit_count == 8'd0) && !state_reg.detect_latched
             && (state_reg.frame_byte_count == '0) && !state_reg.bad_word_seen))
        else $error("restart did not clear state");

    // skid slot only fills while the output slot is held
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with output slot empty");

endmodule
